// ===== sv/bnic_pkg.sv =====
// Shared types and constants for the channels-last batch normalization block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bnic_pkg;

    // Table geometry.
    localparam int MAX_CHANNELS = 64;
    localparam int CH_W         = $clog2(MAX_CHANNELS);

    // Back-end pipeline geometry.
    localparam int DIV_BITS    = 63;   // quotient bits of 2^62 / D
    localparam int SQRT_STEPS  = 32;   // digit steps of the integer square root
    localparam int STG_DIV0    = 1;
    localparam int STG_SQRT0   = STG_DIV0 + DIV_BITS;
    localparam int STG_MUL     = STG_SQRT0 + SQRT_STEPS;
    localparam int STG_XBAR    = STG_MUL + 1;
    localparam int STG_PP      = STG_XBAR + 1;
    localparam int STG_PROD    = STG_PP + 1;
    localparam int STG_LAST    = STG_PROD + 1;
    localparam int NUM_STAGES  = STG_LAST + 1;

    // Queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Configuration register indexes.
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] REG_EPSILON       = 2'd1;
    localparam logic [1:0] REG_USE_GAMMA     = 2'd2;
    localparam logic [1:0] REG_USE_BETA      = 2'd3;

    // Item actions.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [CH_W-1:0]    channel;
        logic signed [31:0] sample;
        logic signed [31:0] param_mean;
        logic [31:0]        param_variance;
        logic signed [31:0] param_gamma;
        logic signed [31:0] param_beta;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [CH_W-1:0]    result_channel;
        logic               row_end;
    } out_item_t;

    typedef struct packed {
        logic [6:0]  channel_count;
        logic [15:0] epsilon;
        logic        use_gamma;
        logic        use_beta;
    } cfg_t;

    // One channel's stored parameters.
    typedef struct packed {
        logic [31:0] mean;
        logic [31:0] variance;
        logic [31:0] gamma;
        logic [31:0] beta;
    } param_t;

    // Sample item after the table lookup, queued for the back end.
    typedef struct packed {
        logic [31:0]     sample;
        param_t          prm;
        logic [CH_W-1:0] ch;
        logic            row_end;
    } fe_item_t;

    // Per-item control that rides along the back-end pipeline.
    typedef struct packed {
        logic               neg;
        logic               zero_den;
        logic               mag_zero;
        logic signed [31:0] b;
        logic [32:0]        mag_d;
        logic [31:0]        mag_g;
        logic [CH_W-1:0]    ch;
        logic               row_end;
    } ctl_t;

endpackage

`default_nettype wire

// ===== sv/batch_norm_inference_channels_last.sv =====
// Top level of the channels-last batch normalization block.
// Depends on bnic_pkg, bnic_front, bnic_fifo and bnic_back.
//
// Usage:
// - Input channel (in_valid, in_stall, in_data): a load item writes one
//   channel's mean, variance, gamma and beta; a sample item produces one
//   result on the output channel (out_valid, out_stall, out_data).
// - The APB port holds channel_count, epsilon, use_gamma and use_beta at
//   byte addresses 0, 4, 8 and 12. Write them only while the block is idle.
// - Throughput is one item per cycle while the output is not stalled. A
//   sample passes the table read, the queue, then 101 pipeline stages, set
//   by the 63-step division and the 32-step square root that form the
//   reciprocal root.
// - When out_stall is high with a result at the output, the whole back-end
//   pipeline holds; the four-entry queue behind the table read keeps taking
//   items until it plus the lookup in flight would fill it, then in_stall rises.
// - Reset clears all control state and sets the registers to their defaults.
//   The tables are not cleared: a channel must be loaded before it is sampled.
`timescale 1ns / 1ps
`default_nettype none

module batch_norm_inference_channels_last
    import bnic_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t               cfg_reg;
    logic               accept;
    logic               push;
    fe_item_t           push_data;
    logic               pop;
    logic               not_empty;
    fe_item_t           head;
    logic [FIFO_CW-1:0] count;
    logic [1:0]         reg_index;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count <= 7'd64;
            cfg_reg.epsilon       <= 16'd1;
            cfg_reg.use_gamma     <= 1'b1;
            cfg_reg.use_beta      <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index)
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= pwdata[6:0];
                REG_EPSILON:       cfg_reg.epsilon       <= pwdata[15:0];
                REG_USE_GAMMA:     cfg_reg.use_gamma     <= pwdata[0];
                REG_USE_BETA:      cfg_reg.use_beta      <= pwdata[0];
                default:           ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_index)
            REG_CHANNEL_COUNT: prdata = {25'd0, cfg_reg.channel_count};
            REG_EPSILON:       prdata = {16'd0, cfg_reg.epsilon};
            REG_USE_GAMMA:     prdata = {31'd0, cfg_reg.use_gamma};
            REG_USE_BETA:      prdata = {31'd0, cfg_reg.use_beta};
            default:           prdata = 32'd0;
        endcase
    end

    // Hold off input when the queue plus the lookup in flight could fill it.
    assign in_stall = ({1'b0, count} + {{FIFO_CW{1'b0}}, push}) >= (FIFO_CW + 1)'(FIFO_DEPTH);
    assign accept   = in_valid && !in_stall;

    bnic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data)
    );

    bnic_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head),
        .count     (count)
    );

    bnic_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== sv/bnic_front.sv =====
// Front end: parameter tables, load writes and sample lookups.
// Depends on bnic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bnic_front
    import bnic_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t in_data,
    input  wire cfg_t     cfg,
    output logic          push,
    output fe_item_t      push_data
);

    param_t          tbl_mem [0:MAX_CHANNELS-1];
    param_t          rd_reg;
    logic            rd_valid_reg;
    logic [31:0]     sample_reg;
    logic [CH_W-1:0] ch_reg;
    logic            row_end_reg;
    logic            row_end_next;

    // Last channel in use flag.
    assign row_end_next = (cfg.channel_count != 7'd0) &&
                          (({1'b0, in_data.channel} + 7'd1) == cfg.channel_count);

    // Parameter tables: write on load, registered read on every item.
    always_ff @(posedge clk)
    begin
        if (accept && in_data.action == ACT_LOAD)
        begin
            tbl_mem[in_data.channel] <= '{mean:     in_data.param_mean,
                                          variance: in_data.param_variance,
                                          gamma:    in_data.param_gamma,
                                          beta:     in_data.param_beta};
        end
        rd_reg <= tbl_mem[in_data.channel];
        if (accept)
        begin
            sample_reg  <= in_data.sample;
            ch_reg      <= in_data.channel;
            row_end_reg <= row_end_next;
        end
    end

    // Only sample items go on to the back end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= accept && (in_data.action == ACT_SAMPLE);
        end
    end

    assign push      = rd_valid_reg;
    assign push_data = '{sample: sample_reg, prm: rd_reg, ch: ch_reg, row_end: row_end_reg};

endmodule

`default_nettype wire

// ===== sv/bnic_fifo.sv =====
// Short queue of looked-up sample items between front and back end.
// Depends on bnic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bnic_fifo
    import bnic_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire fe_item_t push_data,
    input  wire logic     pop,
    output logic          not_empty,
    output fe_item_t      head,
    output logic [FIFO_CW-1:0] count
);

    fe_item_t           slot_reg [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Storage; the producer never pushes into a full queue.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bnic_back.sv =====
// Back end: pipelined reciprocal square root, scaling and saturation.
// Depends on bnic_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bnic_back
    import bnic_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     head_valid,
    input  wire fe_item_t head,
    output logic          pop,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    logic adv;
    logic vld_reg [0:NUM_STAGES-1];
    ctl_t ctl_reg [0:NUM_STAGES-1];

    logic [32:0] den_reg [0:DIV_BITS-1];
    logic [32:0] rem_reg [0:DIV_BITS-1];
    logic [62:0] q_reg   [1:DIV_BITS];
    logic [63:0] sq_n_reg    [1:SQRT_STEPS];
    logic [63:0] sq_root_reg [1:SQRT_STEPS];

    logic [64:0] p_reg;
    logic [41:0] xbar_reg;
    logic [53:0] ph_reg;
    logic [51:0] pl_reg;
    logic [58:0] prod_reg;
    logic signed [31:0] value_reg;

    // Preparation signals.
    logic signed [32:0] diff;
    logic signed [32:0] g_ext;
    logic [32:0] mag_d;
    logic [31:0] mag_g;
    logic [32:0] den;
    ctl_t        ctl_prep;

    // Per-step division and root signals.
    logic [33:0] div_sh   [0:DIV_BITS-1];
    logic        div_take [0:DIV_BITS-1];
    logic [32:0] div_rem  [0:DIV_BITS-1];
    logic [62:0] div_q    [0:DIV_BITS-1];
    logic [63:0] sq_n_in  [0:SQRT_STEPS-1];
    logic [63:0] sq_r_in  [0:SQRT_STEPS-1];
    logic [63:0] sq_trial [0:SQRT_STEPS-1];
    logic [63:0] sq_n_nx  [0:SQRT_STEPS-1];
    logic [63:0] sq_r_nx  [0:SQRT_STEPS-1];

    // Final combine signals.
    logic [64:0]        xbar_sum;
    logic [51:0]        pl_round;
    logic signed [60:0] sp;
    logic signed [60:0] total;
    logic signed [31:0] value_next;
    ctl_t               ctl_fin;

    // The whole pipeline moves unless a finished item is held at the output.
    assign adv = !(vld_reg[STG_LAST] && out_stall);
    assign pop = adv;

    // Difference, magnitudes, signs and denominator.
    always_comb
    begin
        diff  = $signed({head.sample[31], head.sample}) -
                $signed({head.prm.mean[31], head.prm.mean});
        g_ext = cfg.use_gamma ? $signed({head.prm.gamma[31], head.prm.gamma})
                              : 33'sd65536;
        mag_d = diff[32] ? 33'(-diff) : 33'(diff);
        mag_g = g_ext[32] ? 32'(-g_ext) : g_ext[31:0];
        den   = {1'b0, head.prm.variance} + {17'd0, cfg.epsilon};
        ctl_prep.neg      = diff[32] ^ g_ext[32];
        ctl_prep.zero_den = (den == 33'd0);
        ctl_prep.mag_zero = (mag_d == 33'd0) || (mag_g == 32'd0);
        ctl_prep.b        = cfg.use_beta ? $signed(head.prm.beta) : 32'sd0;
        ctl_prep.mag_d    = mag_d;
        ctl_prep.mag_g    = mag_g;
        ctl_prep.ch       = head.ch;
        ctl_prep.row_end  = head.row_end;
    end

    // Restoring division of 2^62 by the denominator, one quotient bit a stage.
    always_comb
    begin
        for (int j = 0; j < DIV_BITS; j++)
        begin
            div_sh[j]   = {rem_reg[j], 1'(j == 0)};
            div_take[j] = (div_sh[j] >= {1'b0, den_reg[j]});
            div_rem[j]  = div_take[j] ? 33'(div_sh[j] - {1'b0, den_reg[j]})
                                      : div_sh[j][32:0];
        end
        div_q[0] = {62'd0, div_take[0]};
        for (int j = 1; j < DIV_BITS; j++)
        begin
            div_q[j] = {q_reg[j][61:0], div_take[j]};
        end
    end

    // Integer square root of the quotient, one result bit a stage.
    always_comb
    begin
        sq_n_in[0] = {1'b0, q_reg[DIV_BITS]};
        sq_r_in[0] = 64'd0;
        for (int k = 1; k < SQRT_STEPS; k++)
        begin
            sq_n_in[k] = sq_n_reg[k];
            sq_r_in[k] = sq_root_reg[k];
        end
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            sq_trial[k] = sq_r_in[k] + (64'd1 << (62 - 2 * k));
            if (sq_n_in[k] >= sq_trial[k])
            begin
                sq_n_nx[k] = sq_n_in[k] - sq_trial[k];
                sq_r_nx[k] = (sq_r_in[k] >> 1) + (64'd1 << (62 - 2 * k));
            end
            else
            begin
                sq_n_nx[k] = sq_n_in[k];
                sq_r_nx[k] = sq_r_in[k] >> 1;
            end
        end
    end

    // Rounding, sign and saturation.
    always_comb
    begin
        xbar_sum = p_reg + 65'd4194304;
        pl_round = pl_reg + 52'd32768;
        ctl_fin  = ctl_reg[STG_PROD];
        sp       = ctl_fin.neg ? -$signed({2'b00, prod_reg}) : $signed({2'b00, prod_reg});
        total    = sp + 61'(ctl_fin.b);
        if (ctl_fin.zero_den)
        begin
            if (ctl_fin.mag_zero)
            begin
                value_next = ctl_fin.b;
            end
            else
            begin
                value_next = ctl_fin.neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end
        else if (total > 61'sd2147483647)
        begin
            value_next = 32'sh7FFF_FFFF;
        end
        else if (total < -61'sd2147483648)
        begin
            value_next = 32'sh8000_0000;
        end
        else
        begin
            value_next = total[31:0];
        end
    end

    // Datapath registers, all advancing together.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl_prep;
            den_reg[0] <= den;
            rem_reg[0] <= '0;
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            for (int j = 0; j < DIV_BITS; j++)
            begin
                if (j < DIV_BITS - 1)
                begin
                    den_reg[j+1] <= den_reg[j];
                    rem_reg[j+1] <= div_rem[j];
                end
                q_reg[j+1] <= div_q[j];
            end
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                sq_n_reg[k+1]    <= sq_n_nx[k];
                sq_root_reg[k+1] <= sq_r_nx[k];
            end
            p_reg     <= 65'(ctl_reg[STG_MUL-1].mag_d * sq_root_reg[SQRT_STEPS][31:0]);
            xbar_reg  <= xbar_sum[64:23];
            ph_reg    <= 54'(xbar_reg[41:20] * ctl_reg[STG_PP-1].mag_g);
            pl_reg    <= 52'(xbar_reg[19:0] * ctl_reg[STG_PP-1].mag_g);
            prod_reg  <= {1'b0, ph_reg, 4'd0} + {23'd0, pl_round[51:16]};
            value_reg <= value_next;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= head_valid;
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[STG_LAST];
    assign out_data  = '{result_value:   value_reg,
                         result_channel: ctl_reg[STG_LAST].ch,
                         row_end:        ctl_reg[STG_LAST].row_end};

endmodule

`default_nettype wire

// ===== bench/batch_norm_inference_channels_last_tb.sv =====
// Testbench for the channels-last batch normalization block.
// Depends on bnic_pkg and batch_norm_inference_channels_last; self-checking against
// an internal fixed-point model of the normalization.
`timescale 1ns / 1ps

module batch_norm_inference_channels_last_tb;
    import bnic_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    batch_norm_inference_channels_last dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Model copy of the tables and the registers.
    logic [31:0] mean_tab [MAX_CHANNELS];
    logic [31:0] var_tab [MAX_CHANNELS];
    logic [31:0] gamma_tab [MAX_CHANNELS];
    logic [31:0] beta_tab [MAX_CHANNELS];
    cfg_t        cfg;

    out_item_t   pending_results [$];
    int          errors;
    bit          idle_in;
    bit          idle_out;

    // Directed items with an optional typed-in expected value.
    typedef struct {
        in_item_t    item;
        bit          known;
        logic [31:0] value;
    } dir_row_t;

    always #5 clk = ~clk;

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    // Normalizes one sample with the current model tables and registers.
    function automatic out_item_t normalize(in_item_t it);
        out_item_t          r;
        logic signed [63:0] x, m, g, b, diff, sp, v;
        logic [63:0]        den, mag_d, mag_g, rr, xbar, prod;
        logic               neg;
        int                 c;
        c = it.channel;
        x = it.sample;
        m = $signed(mean_tab[c]);
        g = cfg.use_gamma ? 64'($signed(gamma_tab[c])) : 64'sd65536;
        b = cfg.use_beta ? 64'($signed(beta_tab[c])) : 64'sd0;
        diff = x - m;
        den = 64'(var_tab[c]) + 64'(cfg.epsilon);
        mag_d = diff < 0 ? 64'(-diff) : 64'(diff);
        mag_g = g < 0 ? 64'(-g) : 64'(g);
        neg = (diff < 0) != (g < 0);
        if (den == 0)
        begin
            if (mag_d == 0 || mag_g == 0)
                v = b;
            else
                v = neg ? -64'sd2147483648 : 64'sd2147483647;
        end
        else
        begin
            rr = int_sqrt((64'd1 << 62) / den);
            xbar = (mag_d * rr + (64'd1 << 22)) >> 23;
            prod = (((xbar >> 20) * mag_g) << 4) + (((xbar & 64'hFFFFF) * mag_g + 64'h8000) >> 16);
            sp = neg ? -$signed(prod) : $signed(prod);
            v = sp + b;
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            else if (v < -64'sd2147483648)
                v = -64'sd2147483648;
        end
        r.result_value = v[31:0];
        r.result_channel = it.channel;
        r.row_end = (cfg.channel_count != 0 && 7'(c) + 7'd1 == cfg.channel_count);
        return r;
    endfunction

    // Applies one accepted item to the model; returns 1 if a result follows.
    function automatic bit model_item(in_item_t it, output out_item_t r);
        if (it.action == ACT_LOAD)
        begin
            mean_tab[it.channel] = it.param_mean;
            var_tab[it.channel] = it.param_variance;
            gamma_tab[it.channel] = it.param_gamma;
            beta_tab[it.channel] = it.param_beta;
            return 0;
        end
        r = normalize(it);
        return 1;
    endfunction

    // Register write over the APB port.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_CHANNEL_COUNT: cfg.channel_count = val[6:0];
            REG_EPSILON:       cfg.epsilon = val[15:0];
            REG_USE_GAMMA:     cfg.use_gamma = val[0];
            default:           cfg.use_beta = val[0];
        endcase
    endtask

    task automatic set_cfg(logic [6:0] cc, logic [15:0] eps, bit ug, bit ub);
        write_reg(REG_CHANNEL_COUNT, 32'(cc));
        write_reg(REG_EPSILON, 32'(eps));
        write_reg(REG_USE_GAMMA, 32'(ug));
        write_reg(REG_USE_BETA, 32'(ub));
    endtask

    // Drives one item after an optional random idle gap and returns at the edge
    // that accepts it; valid stays high so items can follow back to back.
    task automatic send_item(in_item_t it, bit known, logic [31:0] value);
        out_item_t r;
        int        gap;
        @(negedge clk);
        if (idle_in && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (model_item(it, r))
        begin
            if (known && r.result_value !== value)
            begin
                $error("table value: expected %h actual %h", value, r.result_value);
                errors++;
            end
            pending_results.push_back(r);
        end
    endtask

    // Drops valid, waits for all results, then for the pipeline to drain.
    task automatic drain;
        @(negedge clk);
        in_valid <= 0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(0, 32'h0003FFFF) - 32'h00020000;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t rand_load(int ch);
        in_item_t it;
        it.action = ACT_LOAD;
        it.channel = ch[5:0];
        it.sample = $urandom;
        it.param_mean = rand_word();
        it.param_variance = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40000);
        it.param_gamma = rand_word();
        it.param_beta = rand_word();
        return it;
    endfunction

    // Random phase: reload all channels, then mostly samples.
    task automatic random_phase(int count);
        in_item_t it;
        int       c;
        for (c = 0; c < MAX_CHANNELS; c++)
            send_item(rand_load(c), 0, 0);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                it = rand_load($urandom_range(0, MAX_CHANNELS - 1));
            else
            begin
                it = rand_load(0);
                it.action = ACT_SAMPLE;
                it.channel = $urandom_range(0, MAX_CHANNELS - 1);
                it.sample = rand_word();
            end
            send_item(it, 0, 0);
        end
    endtask

    // Output side: random stall bursts and checking.
    initial
    begin
        int gap;
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (idle_out && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 12);
                out_stall <= 1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result %p", out_data);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_data.result_value !== e.result_value)
                begin
                    $error("result_value: expected %h actual %h", e.result_value,
                           out_data.result_value);
                    errors++;
                end
                if (out_data.result_channel !== e.result_channel)
                begin
                    $error("result_channel: expected %0d actual %0d", e.result_channel,
                           out_data.result_channel);
                    errors++;
                end
                if (out_data.row_end !== e.row_end)
                begin
                    $error("row_end: expected %0d actual %0d", e.row_end, out_data.row_end);
                    errors++;
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        in_item_t it;
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        errors = 0;
        idle_in = 1;
        idle_out = 1;
        cfg = '{channel_count: 7'd64, epsilon: 16'd1, use_gamma: 1'b1, use_beta: 1'b1};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed rows at reset settings; ch 0: mean 0, var 0, gamma 1.0, beta 0.
        it = '0;
        it.action = ACT_LOAD;
        it.param_gamma = 32'sh10000;
        rows.push_back('{it, 0, 0});
        it.channel = 63;
        it.param_mean = 32'sh7FFFFFFF;
        it.param_variance = 32'hFFFFFFFF;
        it.param_gamma = 32'sh80000000;
        it.param_beta = 32'sh80000000;
        rows.push_back('{it, 0, 0});
        it = '0;
        it.action = ACT_SAMPLE;
        it.sample = 0;
        rows.push_back('{it, 1, 32'h0});
        it.sample = 32'sh7FFFFFFF;
        rows.push_back('{it, 1, 32'h7FFFFFFF});
        it.sample = 32'sh80000000;
        rows.push_back('{it, 1, 32'h80000000});
        it.sample = 32'sh1;
        rows.push_back('{it, 0, 0});
        it.channel = 63;
        it.sample = 32'sh80000000;
        rows.push_back('{it, 0, 0});
        it.sample = 32'sh7FFFFFFF;
        rows.push_back('{it, 0, 0});
        foreach (rows[i])
        begin
            row = rows[i];
            send_item(row.item, row.known, row.value);
        end
        drain();

        // Zero denominator: epsilon 0 with ch 0 variance 0, small channel count.
        set_cfg(7'd1, 16'd0, 1, 1);
        it = '0;
        it.action = ACT_SAMPLE;
        it.sample = 32'sh100;
        send_item(it, 1, 32'h7FFFFFFF);
        it.sample = -32'sh100;
        send_item(it, 1, 32'h80000000);
        it.sample = 0;
        send_item(it, 1, 32'h0);
        it.channel = 63;
        send_item(it, 0, 0);
        drain();

        // Random phases across register settings, extremes included.
        set_cfg(7'd64, 16'd65535, 0, 0);
        random_phase(300);
        drain();
        set_cfg(7'd0, 16'd0, 1, 0);
        random_phase(300);
        drain();
        set_cfg(7'(($urandom_range(1, 63))), 16'($urandom), 0, 1);
        random_phase(150);
        drain();
        set_cfg(7'd127, 16'd1, 1, 1);
        random_phase(300);
        drain();
        set_cfg(7'(($urandom_range(1, 64))), 16'($urandom_range(0, 3)), 1, 1);
        random_phase(200);
        // Final stretch with no idling.
        idle_in = 0;
        idle_out = 0;
        random_phase(150);
        drain();

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
